// ----- hw/rtl/dtac_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual thermistor average check: shared package
// Widths, register codes, linearization segment tables and the stage control
// word used by the top level and the per-channel datapath.
// ----------------------------------------------------------------------------
package dtac_pkg;

	// Sample and running average widths.
	localparam int SAMPLE_BITS = 12;
	localparam int AVG_SHIFT   = 3;
	localparam int SUM_W       = 16;
	localparam int AVG_W       = 12;
	localparam int TEMP_W      = 16;

	// Masks off sample bits above SAMPLE_BITS.
	localparam logic [AVG_W-1:0] SAMPLE_MASK = AVG_W'((1 << SAMPLE_BITS) - 1);

	// Stream and configuration port widths.
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 56;
	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 2;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_AGREE_LIMIT = 2'd0,
		REG_LOW_LIMIT   = 2'd1,
		REG_HIGH_LIMIT  = 2'd2
	} cfg_reg_t;

	// Configuration reset values.
	localparam logic [AVG_W-1:0]         AGREE_RESET = 12'd200;
	localparam logic signed [TEMP_W-1:0] LOW_RESET   = -16'sd5120;
	localparam logic signed [TEMP_W-1:0] HIGH_RESET  = 16'sd15360;

	// Linearization datapath widths. The scaled offset is at most 1257 * 25600
	// plus half a slope, which fits 25 bits. The reciprocal shift of 37 keeps
	// the rounded-up reciprocal exact for every numerator below 2^25.
	localparam int MAG_W       = 11;
	localparam int NUM_W       = 25;
	localparam int RECIP_SHIFT = 37;
	localparam int RECIP_W     = 27;
	localparam int QUO_W       = 15;
	localparam int PROD_W      = NUM_W + RECIP_W;
	localparam int SCALE_Q     = 25600;

	// Segments, from the coldest (highest count) down.
	typedef enum logic [2:0] {
		SEG_0 = 3'd0,
		SEG_1 = 3'd1,
		SEG_2 = 3'd2,
		SEG_3 = 3'd3,
		SEG_4 = 3'd4
	} seg_t;

	localparam int BP_0 = 2943;
	localparam int BP_1 = 2502;
	localparam int BP_2 = 2045;
	localparam int BP_3 = 1558;
	localparam int BP_4 = 1257;

	// Slopes in hundredths of a count per degree.
	localparam int SLOPE_0 = 1145;
	localparam int SLOPE_1 = 2205;
	localparam int SLOPE_2 = 3047;
	localparam int SLOPE_3 = 3247;
	localparam int SLOPE_4 = 3010;

	// Base temperatures in Q8.8.
	localparam int BASE_0 = 0 * 256;
	localparam int BASE_1 = 20 * 256;
	localparam int BASE_2 = 35 * 256;
	localparam int BASE_3 = 50 * 256;
	localparam int BASE_4 = 60 * 256;

	// Rounded-up reciprocals of the slopes, scaled by 2^RECIP_SHIFT.
	localparam logic [RECIP_W-1:0] RECIP_0 =
		RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(SLOPE_0) - 64'd1) / 64'(SLOPE_0));
	localparam logic [RECIP_W-1:0] RECIP_1 =
		RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(SLOPE_1) - 64'd1) / 64'(SLOPE_1));
	localparam logic [RECIP_W-1:0] RECIP_2 =
		RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(SLOPE_2) - 64'd1) / 64'(SLOPE_2));
	localparam logic [RECIP_W-1:0] RECIP_3 =
		RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(SLOPE_3) - 64'd1) / 64'(SLOPE_3));
	localparam logic [RECIP_W-1:0] RECIP_4 =
		RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(SLOPE_4) - 64'd1) / 64'(SLOPE_4));

	// Breakpoint of a segment.
	function automatic logic [AVG_W-1:0] seg_bp(input seg_t seg);
		case (seg)
			SEG_0: return AVG_W'(BP_0);
			SEG_1: return AVG_W'(BP_1);
			SEG_2: return AVG_W'(BP_2);
			SEG_3: return AVG_W'(BP_3);
			default: return AVG_W'(BP_4);
		endcase
	endfunction

	// Half a slope, the rounding term of the division.
	function automatic logic [MAG_W-1:0] seg_half(input seg_t seg);
		case (seg)
			SEG_0: return MAG_W'(SLOPE_0 / 2);
			SEG_1: return MAG_W'(SLOPE_1 / 2);
			SEG_2: return MAG_W'(SLOPE_2 / 2);
			SEG_3: return MAG_W'(SLOPE_3 / 2);
			default: return MAG_W'(SLOPE_4 / 2);
		endcase
	endfunction

	// Reciprocal of a slope.
	function automatic logic [RECIP_W-1:0] seg_recip(input seg_t seg);
		case (seg)
			SEG_0: return RECIP_0;
			SEG_1: return RECIP_1;
			SEG_2: return RECIP_2;
			SEG_3: return RECIP_3;
			default: return RECIP_4;
		endcase
	endfunction

	// Base temperature of a segment.
	function automatic logic signed [TEMP_W-1:0] seg_base(input seg_t seg);
		case (seg)
			SEG_0: return TEMP_W'(BASE_0);
			SEG_1: return TEMP_W'(BASE_1);
			SEG_2: return TEMP_W'(BASE_2);
			SEG_3: return TEMP_W'(BASE_3);
			default: return TEMP_W'(BASE_4);
		endcase
	endfunction

	// Load strobes of the pipeline stages inside a channel.
	typedef struct packed {
		logic ld_avg;
		logic ld_num;
		logic ld_quo;
		logic ld_temp;
	} dtac_ctl_t;

endpackage

// ----- hw/rtl/dtac_chan.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual thermistor average check: channel datapath
// Leaky running average of one thermistor and its piecewise linear mapping
// to a Q8.8 temperature, in four pipeline stages.
// ----------------------------------------------------------------------------
module dtac_chan (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  dtac_pkg::dtac_ctl_t                  ctl,
	input  logic [dtac_pkg::AVG_W-1:0]           sample,
	output logic [dtac_pkg::AVG_W-1:0]           avg,
	output logic signed [dtac_pkg::TEMP_W-1:0]   temp
);

	logic [dtac_pkg::SUM_W-1:0]           sum_q;
	logic [dtac_pkg::SUM_W-1:0]           sum_next;
	logic [dtac_pkg::AVG_W-1:0]           avg_s2;

	dtac_pkg::seg_t                       seg;
	logic signed [dtac_pkg::AVG_W:0]      diff;
	logic [dtac_pkg::AVG_W:0]             diff_abs;
	logic [dtac_pkg::MAG_W-1:0]           mag;
	logic [dtac_pkg::NUM_W-1:0]           num;

	logic [dtac_pkg::NUM_W-1:0]           num_s3;
	dtac_pkg::seg_t                       seg_s3;
	logic                                 neg_s3;

	logic [dtac_pkg::PROD_W-1:0]          prod;
	logic [dtac_pkg::QUO_W-1:0]           quo_s4;
	dtac_pkg::seg_t                       seg_s4;
	logic                                 neg_s4;

	logic signed [dtac_pkg::TEMP_W+1:0]   base_ext;
	logic signed [dtac_pkg::TEMP_W+1:0]   temp_ext;
	logic signed [dtac_pkg::TEMP_W-1:0]   temp_sat;
	logic signed [dtac_pkg::TEMP_W-1:0]   temp_s5;

	// Running sum gains the sample and loses the old average, wrapping.
	assign sum_next = sum_q + dtac_pkg::SUM_W'(sample & dtac_pkg::SAMPLE_MASK)
		- dtac_pkg::SUM_W'(avg_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			avg_s2 <= '0;
		end else if (ctl.ld_avg) begin
			sum_q  <= sum_next;
			avg_s2 <= dtac_pkg::AVG_W'(sum_next >> dtac_pkg::AVG_SHIFT);
		end
	end

	// Segment select and scaled offset from the breakpoint.
	always_comb begin
		if (avg_s2 > dtac_pkg::seg_bp(dtac_pkg::SEG_0)) begin
			seg = dtac_pkg::SEG_0;
		end else if (avg_s2 > dtac_pkg::seg_bp(dtac_pkg::SEG_1)) begin
			seg = dtac_pkg::SEG_1;
		end else if (avg_s2 > dtac_pkg::seg_bp(dtac_pkg::SEG_2)) begin
			seg = dtac_pkg::SEG_2;
		end else if (avg_s2 > dtac_pkg::seg_bp(dtac_pkg::SEG_3)) begin
			seg = dtac_pkg::SEG_3;
		end else begin
			seg = dtac_pkg::SEG_4;
		end
		diff     = $signed({1'b0, avg_s2}) - $signed({1'b0, dtac_pkg::seg_bp(seg)});
		diff_abs = diff[dtac_pkg::AVG_W] ? (dtac_pkg::AVG_W + 1)'(0) - diff : diff;
		mag      = diff_abs[dtac_pkg::MAG_W-1:0];
		num      = dtac_pkg::NUM_W'(mag) * dtac_pkg::NUM_W'(dtac_pkg::SCALE_Q)
			+ dtac_pkg::NUM_W'(dtac_pkg::seg_half(seg));
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_num) begin
			num_s3 <= num;
			seg_s3 <= seg;
			neg_s3 <= diff[dtac_pkg::AVG_W];
		end
	end

	// Division by the slope as a multiplication by its reciprocal.
	assign prod = dtac_pkg::PROD_W'(num_s3) * dtac_pkg::PROD_W'(dtac_pkg::seg_recip(seg_s3));

	always_ff @(posedge clk) begin
		if (ctl.ld_quo) begin
			quo_s4 <= prod[dtac_pkg::RECIP_SHIFT +: dtac_pkg::QUO_W];
			seg_s4 <= seg_s3;
			neg_s4 <= neg_s3;
		end
	end

	// Apply the offset to the segment base and saturate to 16 bits.
	always_comb begin
		base_ext = (dtac_pkg::TEMP_W + 2)'(dtac_pkg::seg_base(seg_s4));
		if (neg_s4) begin
			temp_ext = base_ext + $signed({3'b000, quo_s4});
		end else begin
			temp_ext = base_ext - $signed({3'b000, quo_s4});
		end
		if (temp_ext > 18'sd32767) begin
			temp_sat = 16'sh7FFF;
		end else if (temp_ext < -18'sd32768) begin
			temp_sat = 16'sh8000;
		end else begin
			temp_sat = temp_ext[dtac_pkg::TEMP_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_temp) begin
			temp_s5 <= temp_sat;
		end
	end

	assign avg  = avg_s2;
	assign temp = temp_s5;

endmodule

// ----- hw/rtl/dual_thermistor_average_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual thermistor average check
// Averages two thermistor ADC channels, linearizes them to Q8.8 degrees and
// reports a held mean temperature with an agreement and range flag.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes one word per sample pair (channel A in the low
//   twelve bits, channel B above it). The master stream returns one word per
//   input word, in order: both channel temperatures, the held mean and the
//   ok flag.
//   One word is accepted every cycle while the receiver keeps up. Each word
//   passes six registers (input, running average, scaled offset, reciprocal
//   multiply, temperature, output) before its result is valid. The rate is set
//   by the running-sum and held-mean updates, each a loop through one register.
//   Every stage has its own valid bit and loads when the stage after it is
//   free, so bubbles are squeezed out while the receiver stalls; the input
//   stalls only once all six registers hold words. A stalled result holds.
//   Reset clears the running sums, averages, held mean and all valid bits,
//   and loads the configuration registers with their defaults. Configuration
//   writes take effect at once and are meant for idle periods.
// ----------------------------------------------------------------------------
module dual_thermistor_average_check (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Slave stream. s_tdata: sensor_a_sample [11:0], sensor_b_sample [23:12].
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [dtac_pkg::IN_DATA_W-1:0]       s_tdata,
	// Master stream. m_tdata: temp_a [15:0], temp_b [31:16], mean_temp [47:32],
	// temp_ok [48], zero [55:49].
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [dtac_pkg::OUT_DATA_W-1:0]      m_tdata,
	// Configuration write port.
	input  logic                                 cfg_we,
	input  logic [dtac_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [dtac_pkg::CFG_W-1:0]           cfg_wdata
);

	logic [dtac_pkg::AVG_W-1:0]           agree_q;
	logic signed [dtac_pkg::TEMP_W-1:0]   low_q;
	logic signed [dtac_pkg::TEMP_W-1:0]   high_q;

	logic [dtac_pkg::AVG_W-1:0]           a_s1;
	logic [dtac_pkg::AVG_W-1:0]           b_s1;
	logic                                 v_s1;
	logic                                 v_s2;
	logic                                 v_s3;
	logic                                 v_s4;
	logic                                 v_s5;
	logic                                 out_valid_q;

	logic                                 rdy1;
	logic                                 rdy2;
	logic                                 rdy3;
	logic                                 rdy4;
	logic                                 rdy5;
	logic                                 rdy_out;
	logic                                 ld_out;
	dtac_pkg::dtac_ctl_t                  ctl;

	logic [dtac_pkg::AVG_W-1:0]           avg_a;
	logic [dtac_pkg::AVG_W-1:0]           avg_b;
	logic signed [dtac_pkg::TEMP_W-1:0]   temp_a;
	logic signed [dtac_pkg::TEMP_W-1:0]   temp_b;

	logic signed [dtac_pkg::AVG_W:0]      avg_diff;
	logic [dtac_pkg::AVG_W:0]             avg_abs;
	logic                                 agree;
	logic                                 agree_s3;
	logic                                 agree_s4;
	logic                                 agree_s5;

	logic signed [dtac_pkg::TEMP_W:0]     temp_sum;
	logic signed [dtac_pkg::TEMP_W-1:0]   mean;
	logic signed [dtac_pkg::TEMP_W-1:0]   held_q;
	logic signed [dtac_pkg::TEMP_W-1:0]   out_temp_a_q;
	logic signed [dtac_pkg::TEMP_W-1:0]   out_temp_b_q;
	logic signed [dtac_pkg::TEMP_W-1:0]   out_mean_q;
	logic                                 out_ok_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			agree_q <= dtac_pkg::AGREE_RESET;
			low_q   <= dtac_pkg::LOW_RESET;
			high_q  <= dtac_pkg::HIGH_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				dtac_pkg::REG_AGREE_LIMIT: agree_q <= cfg_wdata[dtac_pkg::AVG_W-1:0];
				dtac_pkg::REG_LOW_LIMIT:   low_q   <= cfg_wdata;
				dtac_pkg::REG_HIGH_LIMIT:  high_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Each stage loads when it is empty or the stage after it moves on.
	always_comb begin
		rdy_out     = !out_valid_q || m_tready;
		rdy5        = !v_s5 || rdy_out;
		rdy4        = !v_s4 || rdy5;
		rdy3        = !v_s3 || rdy4;
		rdy2        = !v_s2 || rdy3;
		rdy1        = !v_s1 || rdy2;
		ctl.ld_avg  = rdy2 && v_s1;
		ctl.ld_num  = rdy3 && v_s2;
		ctl.ld_quo  = rdy4 && v_s3;
		ctl.ld_temp = rdy5 && v_s4;
		ld_out      = rdy_out && v_s5;
	end

	assign s_tready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= s_tvalid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
			if (rdy_out) out_valid_q <= v_s5;
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (s_tvalid && rdy1) begin
			a_s1 <= s_tdata[dtac_pkg::AVG_W-1:0];
			b_s1 <= s_tdata[2*dtac_pkg::AVG_W-1:dtac_pkg::AVG_W];
		end
	end

	dtac_chan u_chan_a (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.sample (a_s1),
		.avg    (avg_a),
		.temp   (temp_a)
	);

	dtac_chan u_chan_b (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.sample (b_s1),
		.avg    (avg_b),
		.temp   (temp_b)
	);

	// Agreement of the two averages, carried along with the channel stages.
	always_comb begin
		avg_diff = $signed({1'b0, avg_a}) - $signed({1'b0, avg_b});
		avg_abs  = avg_diff[dtac_pkg::AVG_W] ?
			(dtac_pkg::AVG_W + 1)'(0) - avg_diff : avg_diff;
		agree    = avg_abs[dtac_pkg::AVG_W-1:0] < agree_q;
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_num)  agree_s3 <= agree;
		if (ctl.ld_quo)  agree_s4 <= agree_s3;
		if (ctl.ld_temp) agree_s5 <= agree_s4;
	end

	// Mean of both temperatures, rounded toward minus infinity.
	assign temp_sum = $signed({temp_a[dtac_pkg::TEMP_W-1], temp_a})
		+ $signed({temp_b[dtac_pkg::TEMP_W-1], temp_b});
	assign mean = temp_sum[dtac_pkg::TEMP_W:1];

	// Held mean updates only on agreement.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (ld_out && agree_s5) begin
			held_q <= mean;
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (ld_out) begin
			out_temp_a_q <= temp_a;
			out_temp_b_q <= temp_b;
			out_mean_q   <= agree_s5 ? mean : held_q;
			out_ok_q     <= agree_s5 && (mean > low_q) && (mean < high_q);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0000000, out_ok_q, out_mean_q, out_temp_b_q, out_temp_a_q};

endmodule

// ----- hw/rtl/dtac_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual thermistor average check: port checker
// Watches the stream ports of the top level and checks result consistency
// and the number of words in flight.
// ----------------------------------------------------------------------------
module dtac_check (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	input  logic                                 s_tready,
	input  logic                                 m_tvalid,
	input  logic                                 m_tready,
	input  logic [dtac_pkg::OUT_DATA_W-1:0]      m_tdata
);

	logic [2:0]                           in_flight_q;
	logic                                 in_acc;
	logic                                 out_acc;
	logic signed [dtac_pkg::TEMP_W:0]     sum_chk;

	assign in_acc   = s_tvalid && s_tready;
	assign out_acc  = m_tvalid && m_tready;
	assign sum_chk  = $signed({m_tdata[15], m_tdata[15:0]})
		+ $signed({m_tdata[31], m_tdata[31:16]});

	// Words accepted but not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_flight_q <= '0;
		end else if (in_acc && !out_acc) begin
			in_flight_q <= in_flight_q + 3'd1;
		end else if (out_acc && !in_acc) begin
			in_flight_q <= in_flight_q - 3'd1;
		end
	end

	// A stalled result holds its word.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// A flagged result carries the mean of its own two temperatures.
	a_mean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[48] |-> m_tdata[47:32] == sum_chk[16:1])
		else $error("ok flag set with a mean that does not match");

	// No result without an accepted word behind it.
	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> in_flight_q != 3'd0)
		else $error("result without a pending input word");

	// With six words inside and the receiver stalled, the input is closed.
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		in_flight_q == 3'd6 && !m_tready |-> !s_tready)
		else $error("pipeline holds too many words");

endmodule

bind dual_thermistor_average_check dtac_check u_dtac_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual thermistor average check: self-checking testbench
// Streams sample pairs into the block and predicts every output word from a
// local model of the running averages, the five-segment linearization, the
// agreement test and the held mean. Runs a short directed set on the reset
// configuration, then level-following random runs under several register
// settings, with random gaps on both streams and long output stalls.
// ----------------------------------------------------------------------------
module tb;

	// Register index with no register behind it; writes there are dropped.
	localparam logic [dtac_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	// Local copy of the averaging and linearization constants.
	localparam int SHIFT        = 3;
	localparam int KNEE_0       = 2943;
	localparam int KNEE_1       = 2502;
	localparam int KNEE_2       = 2045;
	localparam int KNEE_3       = 1558;
	localparam int KNEE_4       = 1257;
	localparam int COUNT_MAX    = 4095;
	localparam int LONG_HOLD    = 64;
	localparam int DRAIN_CYCLES = 12;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_PAIRS = 135;
	localparam int SETTINGS_N   = 8;

	// One output word, split into fields.
	typedef struct {
		logic signed [dtac_pkg::TEMP_W-1:0] temp_a;
		logic signed [dtac_pkg::TEMP_W-1:0] temp_b;
		logic signed [dtac_pkg::TEMP_W-1:0] mean_temp;
		logic                               temp_ok;
		logic [6:0]                         pad;
	} reading_t;

	logic                                clk;
	logic                                arst_n    = 1'b0;
	logic                                s_tvalid  = 1'b0;
	logic                                s_tready;
	logic [dtac_pkg::IN_DATA_W-1:0]      s_tdata   = '0;
	logic                                m_tvalid;
	logic                                m_tready  = 1'b0;
	logic [dtac_pkg::OUT_DATA_W-1:0]     m_tdata;
	logic                                cfg_we    = 1'b0;
	logic [dtac_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
	logic [dtac_pkg::CFG_W-1:0]          cfg_wdata = '0;

	// Mirror of the block state and configuration.
	logic [dtac_pkg::SUM_W-1:0]          sum_a     = '0;
	logic [dtac_pkg::SUM_W-1:0]          sum_b     = '0;
	logic [dtac_pkg::AVG_W-1:0]          avg_a     = '0;
	logic [dtac_pkg::AVG_W-1:0]          avg_b     = '0;
	logic signed [dtac_pkg::TEMP_W-1:0]  held_mean = '0;
	logic [dtac_pkg::AVG_W-1:0]          agree_lim = 12'd200;
	logic signed [dtac_pkg::TEMP_W-1:0]  low_lim   = -16'sd5120;
	logic signed [dtac_pkg::TEMP_W-1:0]  high_lim  = 16'sd15360;

	logic [dtac_pkg::IN_DATA_W-1:0]      pending_pairs[$];
	reading_t                            expected_readings[$];
	reading_t                            seen, want;

	// Test flow controls; the sequence alone sets the first three, at falling edges.
	bit                        idling         = 1'b1;
	bit                        stall_on_entry = 1'b0;
	int                        phase_no       = 0;
	int                        seen_phase     = 0;
	int                        hold_left      = 0;

	int                        cycle_count    = 0;
	int                        pairs_sent     = 0;
	int                        words_checked  = 0;
	int                        ok_words       = 0;
	int                        mismatch_count = 0;
	int                        settings_used  = 1;

	dual_thermistor_average_check uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Piecewise linear map of an average count to Q8.8 degrees, saturated.
	function automatic int counts_to_degrees(input logic [dtac_pkg::AVG_W-1:0] avg);
		int a, knee, slope, base, d, m, q, t;
		a = avg;
		if (a > KNEE_0) begin
			knee = KNEE_0; slope = 1145; base = 0;
		end else if (a > KNEE_1) begin
			knee = KNEE_1; slope = 2205; base = 20;
		end else if (a > KNEE_2) begin
			knee = KNEE_2; slope = 3047; base = 35;
		end else if (a > KNEE_3) begin
			knee = KNEE_3; slope = 3247; base = 50;
		end else begin
			knee = KNEE_4; slope = 3010; base = 60;
		end
		d = a - knee;
		m = (d < 0) ? -d : d;
		// Offset rounded to nearest, ties away from zero.
		q = (m * 25600 + slope / 2) / slope;
		t = base * 256;
		t = (d < 0) ? t + q : t - q;
		if (t > 32767) t = 32767;
		if (t < -32768) t = -32768;
		return t;
	endfunction

	// Advances both channels by one accepted word and queues the expected reading.
	task automatic predict_reading(input logic [dtac_pkg::IN_DATA_W-1:0] word);
		int ta, tb, gap, mean;
		reading_t r;
		sum_a = sum_a + {4'd0, word[11:0]} - {4'd0, avg_a};
		avg_a = dtac_pkg::AVG_W'(sum_a >> SHIFT);
		sum_b = sum_b + {4'd0, word[23:12]} - {4'd0, avg_b};
		avg_b = dtac_pkg::AVG_W'(sum_b >> SHIFT);
		ta = counts_to_degrees(avg_a);
		tb = counts_to_degrees(avg_b);
		gap = int'(avg_a) - int'(avg_b);
		if (gap < 0) gap = -gap;
		r.temp_ok = 1'b0;
		if (gap < int'(agree_lim)) begin
			// Mean rounds toward minus infinity.
			mean = (ta + tb) >>> 1;
			held_mean = dtac_pkg::TEMP_W'(mean);
			r.temp_ok = (mean > int'(low_lim)) && (mean < int'(high_lim));
		end
		r.temp_a = dtac_pkg::TEMP_W'(ta);
		r.temp_b = dtac_pkg::TEMP_W'(tb);
		r.mean_temp = held_mean;
		r.pad = '0;
		expected_readings.push_back(r);
	endtask

	task automatic program_register(input logic [dtac_pkg::CFG_IDX_W-1:0] idx,
	                                input logic [dtac_pkg::CFG_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			dtac_pkg::REG_AGREE_LIMIT: agree_lim = data[dtac_pkg::AVG_W-1:0];
			dtac_pkg::REG_LOW_LIMIT:   low_lim = data;
			dtac_pkg::REG_HIGH_LIMIT:  high_lim = data;
			default: ;
		endcase
	endtask

	task automatic push_pair(input int a, input int b);
		if (a < 0) a = 0;
		if (a > COUNT_MAX) a = COUNT_MAX;
		if (b < 0) b = 0;
		if (b > COUNT_MAX) b = COUNT_MAX;
		pending_pairs.push_back({12'(b), 12'(a)});
	endtask

	// A plateau level: near a knee, near a rail, or anywhere.
	function automatic int pick_level();
		int knee;
		case ($urandom_range(0, 4))
			0: knee = KNEE_0;
			1: knee = KNEE_1;
			2: knee = KNEE_2;
			3: knee = KNEE_3;
			default: knee = KNEE_4;
		endcase
		case ($urandom_range(0, 3))
			0: return knee + $urandom_range(0, 2) - 1;
			1: return $urandom_range(0, 1) ? $urandom_range(0, 8) : COUNT_MAX - $urandom_range(0, 8);
			default: return $urandom_range(0, COUNT_MAX);
		endcase
	endfunction

	// Runs of samples that follow a plateau so the averages settle, with some
	// scattered noise words and channel pairs that drift apart.
	task automatic fill_random(input int n);
		int count, la, lb, jitter, len;
		count = 0;
		while (count < n) begin
			if ($urandom_range(0, 9) == 0) begin
				push_pair($urandom_range(0, COUNT_MAX), $urandom_range(0, COUNT_MAX));
				count++;
			end else begin
				la = pick_level();
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: lb = la + $urandom_range(0, 40) - 20;
					6, 7: lb = la + $urandom_range(0, 800) - 400;
					default: lb = pick_level();
				endcase
				jitter = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
				len = $urandom_range(6, 48);
				for (int i = 0; i < len && count < n; i++) begin
					push_pair(la + $urandom_range(0, 2 * jitter) - jitter,
					          lb + $urandom_range(0, 2 * jitter) - jitter);
					count++;
				end
			end
		end
	endtask

	task automatic start_phase(input bit quiet, input bit stall);
		@(negedge clk);
		idling = !quiet;
		stall_on_entry = stall;
		phase_no++;
	endtask

	// Holds the sender until every word has come back, then lets the pipe drain.
	task automatic finish_phase();
		@(negedge clk);
		while (pending_pairs.size() != 0 || s_tvalid || expected_readings.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Input side: offers queued words, with random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_reading(s_tdata);
				pairs_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_pairs.size() != 0 && !(idling && $urandom_range(0, 99) < 29)) begin
					s_tvalid <= 1'b1;
					s_tdata  <= pending_pairs.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off at the start of a phase, counted here.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left  <= 0;
			seen_phase <= 0;
		end else if (phase_no != seen_phase) begin
			seen_phase <= phase_no;
			if (stall_on_entry)
				hold_left <= LONG_HOLD;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Output side: checks each accepted word against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen.temp_a    = m_tdata[15:0];
				seen.temp_b    = m_tdata[31:16];
				seen.mean_temp = m_tdata[47:32];
				seen.temp_ok   = m_tdata[48];
				seen.pad       = m_tdata[55:49];
				if (expected_readings.size() == 0) begin
					$error("output word with no sample pair pending");
					mismatch_count++;
				end else begin
					want = expected_readings.pop_front();
					words_checked++;
					if (want.temp_ok)
						ok_words++;
					if (seen.temp_a !== want.temp_a) begin
						$error("temp_a: expected %0d, got %0d", want.temp_a, seen.temp_a);
						mismatch_count++;
					end
					if (seen.temp_b !== want.temp_b) begin
						$error("temp_b: expected %0d, got %0d", want.temp_b, seen.temp_b);
						mismatch_count++;
					end
					if (seen.mean_temp !== want.mean_temp) begin
						$error("mean_temp: expected %0d, got %0d", want.mean_temp,
						       seen.mean_temp);
						mismatch_count++;
					end
					if (seen.temp_ok !== want.temp_ok) begin
						$error("temp_ok: expected %0d, got %0d", want.temp_ok, seen.temp_ok);
						mismatch_count++;
					end
					if (seen.pad !== want.pad) begin
						$error("pad: expected %0d, got %0d", want.pad, seen.pad);
						mismatch_count++;
					end
				end
			end
			m_tready <= (hold_left <= 1) && !(idling && $urandom_range(0, 99) < 29);
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Test sequence.
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed words on the reset configuration: rails, crossed rails,
		// a settle at full scale and plateaus around the knees.
		start_phase(1'b0, 1'b0);
		push_pair(0, 0);
		push_pair(COUNT_MAX, COUNT_MAX);
		push_pair(COUNT_MAX, 0);
		push_pair(0, COUNT_MAX);
		for (int i = 0; i < 8; i++)
			push_pair(COUNT_MAX, COUNT_MAX);
		for (int i = 0; i < 6; i++)
			push_pair(KNEE_0 + 1, KNEE_0);
		for (int i = 0; i < 4; i++)
			push_pair(KNEE_4, KNEE_3);
		for (int i = 0; i < 3; i++)
			push_pair(KNEE_1, KNEE_2);
		finish_phase();

		for (int s = 0; s < SETTINGS_N; s++) begin
			case (s)
				0: begin
					// All but a full-scale gap agree; limits at the ends of the range.
					program_register(dtac_pkg::REG_AGREE_LIMIT, 16'hFFFF);
					program_register(dtac_pkg::REG_LOW_LIMIT, 16'h8000);
					program_register(dtac_pkg::REG_HIGH_LIMIT, 16'h7FFF);
				end
				1: begin
					// Nothing agrees; empty window.
					program_register(dtac_pkg::REG_AGREE_LIMIT, 16'h0000);
					program_register(dtac_pkg::REG_LOW_LIMIT, 16'h0000);
					program_register(dtac_pkg::REG_HIGH_LIMIT, 16'h0000);
				end
				2: begin
					// Only equal averages agree; a write to the spare index is dropped.
					program_register(dtac_pkg::REG_AGREE_LIMIT, 16'h0001);
					program_register(dtac_pkg::REG_LOW_LIMIT, 16'hEC00);
					program_register(dtac_pkg::REG_HIGH_LIMIT, 16'h3C00);
					program_register(REG_SPARE, dtac_pkg::CFG_W'($urandom));
				end
				3: begin
					// Limits crossed at the extremes.
					program_register(dtac_pkg::REG_AGREE_LIMIT, 16'd200);
					program_register(dtac_pkg::REG_LOW_LIMIT, 16'h7FFF);
					program_register(dtac_pkg::REG_HIGH_LIMIT, 16'h8000);
				end
				default: begin
					program_register(dtac_pkg::REG_AGREE_LIMIT,
					                 {4'($urandom), 12'($urandom_range(0, 600))});
					if ($urandom_range(0, 1)) begin
						program_register(dtac_pkg::REG_LOW_LIMIT,
						                 dtac_pkg::CFG_W'($urandom));
						program_register(dtac_pkg::REG_HIGH_LIMIT,
						                 dtac_pkg::CFG_W'($urandom));
					end else begin
						program_register(dtac_pkg::REG_LOW_LIMIT,
						                 dtac_pkg::CFG_W'($urandom_range(0, 9000) - 8000));
						program_register(dtac_pkg::REG_HIGH_LIMIT,
						                 dtac_pkg::CFG_W'($urandom_range(0, 14000) + 6000));
					end
					program_register(REG_SPARE, dtac_pkg::CFG_W'($urandom));
				end
			endcase
			settings_used++;
			// One phase runs with no gaps on either side.
			start_phase(s == 6, 1'b1);
			fill_random(RANDOM_PAIRS);
			finish_phase();
		end

		$display("Sent %0d sample pairs under %0d register settings; %0d words checked,",
		         pairs_sent, settings_used, words_checked);
		$display("%0d of them in range, with %0d mismatches.", ok_words, mismatch_count);
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
